FILE: design/lfu_page_replacement_defines.svh
// Assertion macros shared by the page replacement block.
`ifndef LFU_PAGE_REPLACEMENT_DEFINES_SVH
`define LFU_PAGE_REPLACEMENT_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define LFU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define LFU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/lfu_pkg.sv
`timescale 1ns / 1ps

package lfu_pkg;

    localparam int PAGE_W = 32;
    localparam int USE_W  = 32;
    localparam int TIME_W = 48;
    localparam int CNT_W  = 48;
    localparam int CFG_W  = 5;
    localparam int ROW_W  = PAGE_W + USE_W + TIME_W;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;   // item transfer: latch page, clear search
        logic rd_en;   // read the table row at the scan address
        logic commit;  // write the chosen row and load the result
    } t_lfu_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_addr;  // scan address is at the final row
        logic out_free;   // result register can take a new result
    } t_lfu_sts;

    function automatic logic [CNT_W-1:0] sat_inc48(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    endfunction

    function automatic logic [USE_W-1:0] sat_inc32(input logic [USE_W-1:0] v);
        return (v == {USE_W{1'b1}}) ? v : v + USE_W'(1);
    endfunction

endpackage

FILE: design/lfu_page_replacement.sv
`timescale 1ns / 1ps
// LFU page replacement with LRU tie-break.
// Input channel (i_in_valid / o_in_ready) carries one page reference,
// i_page_id. Each reference gives one result on the output channel
// (o_out_valid / i_out_ready): o_fault, o_reference_total, o_fault_total.
// The configuration channel (i_cfg_valid / o_cfg_ready, i_cfg_data) sets
// the cache size; it is always ready. The user must write the cache size
// only while idle; the block itself does not enforce this. Each reference
// reads every table row once through the single read port of the table
// memory. One reference is in work at a time; the next is taken while the
// last result waits in the output register. If the receiver stalls, the
// following reference completes its scan and then holds until the waiting
// result is taken.
// Reset (synchronous, active low) empties the table, clears both counters
// and sets the cache size to 16. No clearing pass is needed.

module lfu_page_replacement #(
    parameter int ENTRIES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [lfu_pkg::PAGE_W-1:0]  i_page_id,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_fault,
    output logic [lfu_pkg::CNT_W-1:0]   o_reference_total,
    output logic [lfu_pkg::CNT_W-1:0]   o_fault_total,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [lfu_pkg::CFG_W-1:0]   i_cfg_data
);

    import lfu_pkg::*;

    t_lfu_cmd          cmd;
    t_lfu_sts          sts;
    logic [CFG_W-1:0]  r_active;

    // Cache size register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= CFG_RESET;
        end else if (i_cfg_valid) begin
            r_active <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    lfu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lfu_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_page_id         (i_page_id),
        .i_active          (r_active),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_fault           (o_fault),
        .o_reference_total (o_reference_total),
        .o_fault_total     (o_fault_total)
    );

endmodule

FILE: design/lfu_ram.sv
`timescale 1ns / 1ps

module lfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: design/lfu_ctrl.sv
`timescale 1ns / 1ps
`include "lfu_page_replacement_defines.svh"

module lfu_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  lfu_pkg::t_lfu_sts i_sts,
    output lfu_pkg::t_lfu_cmd o_cmd
);

    import lfu_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_COMMIT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands.
    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.start = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd_en = 1'b1;
                if (i_sts.last_addr) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `LFU_ASSERT(a_commit_needs_room, i_clk, i_rst_n, o_cmd.commit |-> i_sts.out_free, "commit while result register is full")
    `LFU_ASSERT(a_start_then_read, i_clk, i_rst_n, o_cmd.start |=> o_cmd.rd_en, "scan did not follow an input transfer")
    `LFU_ASSERT(a_ready_not_busy, i_clk, i_rst_n, o_in_ready |-> !o_cmd.rd_en && !o_cmd.commit, "ready while an item is in work")

endmodule

FILE: design/lfu_dp.sv
`timescale 1ns / 1ps
`include "lfu_page_replacement_defines.svh"

module lfu_dp #(
    parameter int ENTRIES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lfu_pkg::t_lfu_cmd           i_cmd,
    output lfu_pkg::t_lfu_sts           o_sts,
    input  logic [lfu_pkg::PAGE_W-1:0]  i_page_id,
    input  logic [lfu_pkg::CFG_W-1:0]   i_active,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_fault,
    output logic [lfu_pkg::CNT_W-1:0]   o_reference_total,
    output logic [lfu_pkg::CNT_W-1:0]   o_fault_total
);

    import lfu_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int XW = (CW > CFG_W) ? CW : CFG_W;

    logic [ENTRIES-1:0] r_valid;
    logic [CW-1:0]      r_occupied;
    logic [CNT_W-1:0]   r_ref_cnt;
    logic [CNT_W-1:0]   r_fault_cnt;
    logic [PAGE_W-1:0]  r_page;
    logic [AW-1:0]      r_addr;
    logic               r_rd_vld;
    logic [AW-1:0]      r_rd_idx;

    logic               r_hit;
    logic [AW-1:0]      r_hit_idx;
    logic [USE_W-1:0]   r_hit_uses;
    logic               r_found;
    logic [AW-1:0]      r_best_idx;
    logic [USE_W-1:0]   r_best_uses;
    logic [TIME_W-1:0]  r_best_time;
    logic               r_free_found;
    logic [AW-1:0]      r_free_idx;

    logic               r_out_valid;
    logic               r_out_fault;
    logic [CNT_W-1:0]   r_out_ref;
    logic [CNT_W-1:0]   r_out_flt;

    logic [ROW_W-1:0]   rd_data;
    logic [PAGE_W-1:0]  rd_page;
    logic [USE_W-1:0]   rd_uses;
    logic [TIME_W-1:0]  rd_time;
    logic               row_live;
    logic               better;

    logic [XW-1:0]      act_x;
    logic [XW-1:0]      cap_x;
    logic               full;
    logic [AW-1:0]      slot;
    logic [USE_W-1:0]   wr_uses;
    logic [ROW_W-1:0]   wr_data;
    logic [CNT_W-1:0]   n_fault_cnt;

    // Table rows: page, use count, time of last use.
    lfu_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ENTRIES),
        .AW    (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.commit),
        .i_wr_addr (slot),
        .i_wr_data (wr_data),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (r_addr),
        .o_rd_data (rd_data)
    );

    assign rd_page = rd_data[ROW_W-1 -: PAGE_W];
    assign rd_uses = rd_data[TIME_W +: USE_W];
    assign rd_time = rd_data[TIME_W-1:0];

    // Evaluation of the row returned this cycle.
    assign row_live = r_rd_vld && r_valid[r_rd_idx];
    assign better   = !r_found || (rd_uses < r_best_uses) ||
                      ((rd_uses == r_best_uses) && (rd_time < r_best_time));

    // Effective cache size: zero acts as one, clipped to the table depth.
    always_comb begin
        act_x = XW'(i_active);
        if (act_x == '0) begin
            cap_x = XW'(1);
        end else if (act_x > XW'(ENTRIES)) begin
            cap_x = XW'(ENTRIES);
        end else begin
            cap_x = act_x;
        end
    end

    assign full = XW'(r_occupied) >= cap_x;

    // Row to write on commit.
    always_comb begin
        if (r_hit) begin
            slot = r_hit_idx;
        end else if (full) begin
            slot = r_best_idx;
        end else begin
            slot = r_free_idx;
        end
    end

    assign wr_uses     = r_hit ? sat_inc32(r_hit_uses) : USE_W'(1);
    assign wr_data     = {r_page, wr_uses, r_ref_cnt};
    assign n_fault_cnt = r_hit ? r_fault_cnt : sat_inc48(r_fault_cnt);

    assign o_sts.last_addr = (r_addr == AW'(ENTRIES - 1));
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    // Control state: valid bits, occupancy, counters, scan and result flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_occupied   <= '0;
            r_ref_cnt    <= '0;
            r_fault_cnt  <= '0;
            r_addr       <= '0;
            r_rd_vld     <= 1'b0;
            r_hit        <= 1'b0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
            if (i_cmd.start) begin
                r_ref_cnt    <= sat_inc48(r_ref_cnt);
                r_addr       <= '0;
                r_hit        <= 1'b0;
                r_found      <= 1'b0;
                r_free_found <= 1'b0;
            end
            if (i_cmd.rd_en) begin
                r_addr <= r_addr + AW'(1);
            end
            if (row_live) begin
                if (rd_page == r_page) begin
                    r_hit <= 1'b1;
                end
                r_found <= 1'b1;
            end else if (r_rd_vld) begin
                r_free_found <= 1'b1;
            end
            if (i_cmd.commit) begin
                r_valid[slot] <= 1'b1;
                r_fault_cnt   <= n_fault_cnt;
                if (!r_hit && !full) begin
                    r_occupied <= r_occupied + CW'(1);
                end
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers of the search and the result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_page <= i_page_id;
        end
        if (i_cmd.rd_en) begin
            r_rd_idx <= r_addr;
        end
        if (row_live) begin
            if (rd_page == r_page && !r_hit) begin
                r_hit_idx  <= r_rd_idx;
                r_hit_uses <= rd_uses;
            end
            if (better) begin
                r_best_idx  <= r_rd_idx;
                r_best_uses <= rd_uses;
                r_best_time <= rd_time;
            end
        end else if (r_rd_vld && !r_free_found) begin
            r_free_idx <= r_rd_idx;
        end
        if (i_cmd.commit) begin
            r_out_fault <= !r_hit;
            r_out_ref   <= r_ref_cnt;
            r_out_flt   <= n_fault_cnt;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_fault           = r_out_fault;
    assign o_reference_total = r_out_ref;
    assign o_fault_total     = r_out_flt;

    `LFU_ASSERT_ALWAYS(a_occ_matches_valid, i_clk, $countones(r_valid) == int'(r_occupied), "occupancy differs from valid bits")
    `LFU_ASSERT(a_commit_shows_result, i_clk, i_rst_n, i_cmd.commit |=> o_out_valid, "commit did not present a result")
    `LFU_ASSERT(a_faults_le_refs, i_clk, i_rst_n, r_fault_cnt <= r_ref_cnt, "fault count above reference count")

endmodule
